// ----- src/atr_pkg.sv -----
// atr_pkg: shared types and constants for the average true range tracker
// no dependencies; used by atr_front, atr_back and the top level core
`default_nettype none

package atr_pkg;

   // width of the count of ranges in the mean, also the width of the window register
   localparam int CNT_W = 9;

   // width of the configuration register index
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_INITIAL_CLOSE = 1'b1
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic [CNT_W-1:0] WINDOW_RESET = 9'd14;
   localparam logic [47:0]      CLOSE_RESET  = 48'd6553600;

   // entries of the queue between the front and back ends
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_UPDATE,
      BK_DIVIDE,
      BK_OUTPUT
   } back_state_type;

endpackage

`default_nettype wire

// ----- src/atr_ram.sv -----
// atr_ram: generic single write, single read memory with registered read data
// no dependencies
`default_nettype none

module atr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- src/atr_fifo.sv -----
// atr_fifo: short register queue between the front and back ends
// no dependencies
`default_nettype none

module atr_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/atr_front.sv -----
// atr_front: accepts price bars, tracks the previous close, forms the true range
// depends on atr_pkg; feeds atr_fifo
`default_nettype none

module atr_front #(
   parameter int PRICE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire logic [PRICE_BITS-1:0] clear_close,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [PRICE_BITS-1:0] req_high_price,
   input  wire logic [PRICE_BITS-1:0] req_low_price,
   input  wire logic [PRICE_BITS-1:0] req_close_price,
   input  wire logic                  queue_full,
   output logic                       queue_push,
   output logic      [PRICE_BITS-1:0] queue_data
);

   logic                  stage_valid_ff, stage_valid_in;
   logic [PRICE_BITS-1:0] last_close_ff, last_close_in;
   logic [PRICE_BITS-1:0] hl_ff, hl_in;
   logic [PRICE_BITS-1:0] hc_ff, hc_in;
   logic [PRICE_BITS-1:0] lc_ff, lc_in;
   logic                  accept;
   logic [PRICE_BITS-1:0] max_a;

   assign req_stall  = stage_valid_ff && queue_full;
   assign accept     = req_valid && !req_stall;
   assign queue_push = stage_valid_ff && !queue_full;

   // stage one: the three distances, low above high gives zero span
   always_comb begin
      hl_in = (req_high_price >= req_low_price) ? req_high_price - req_low_price : '0;
      hc_in = (req_high_price >= last_close_ff) ? req_high_price - last_close_ff
                                                 : last_close_ff - req_high_price;
      lc_in = (req_low_price >= last_close_ff) ? req_low_price - last_close_ff
                                                : last_close_ff - req_low_price;
   end

   // stage two: largest of the three
   always_comb begin
      max_a      = (hc_ff > hl_ff) ? hc_ff : hl_ff;
      queue_data = (lc_ff > max_a) ? lc_ff : max_a;
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      last_close_in  = last_close_ff;
      if (queue_push) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in = 1'b1;
         last_close_in  = req_close_price;
      end
      if (clear) begin
         last_close_in = clear_close;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         last_close_ff  <= PRICE_BITS'(atr_pkg::CLOSE_RESET);
      end else begin
         stage_valid_ff <= stage_valid_in;
         last_close_ff  <= last_close_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hl_ff <= hl_in;
         hc_ff <= hc_in;
         lc_ff <= lc_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/atr_div.sv -----
// atr_div: restoring radix-2 divider, one quotient bit per cycle
// no dependencies; used by atr_back
`default_nettype none

module atr_div #(
   parameter int DIVIDEND_W = 41,
   parameter int DIVISOR_W  = 9
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  abort,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic      [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  running_ff, running_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W:0]    shifted;
   logic                  fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      shifted    = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits       = (shifted >= {1'b0, div_ff});
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      if (start) begin
         running_in = 1'b1;
         step_in    = STEP_W'(DIVIDEND_W);
         quo_in     = dividend;
         rem_in     = '0;
         div_in     = divisor;
      end else if (running_ff) begin
         // remainder stays below the divisor, so the top bit drops out
         rem_in  = fits ? DIVISOR_W'(shifted - {1'b0, div_ff}) : shifted[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
      if (abort) begin
         running_in = 1'b0;
         done_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         step_ff    <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

`default_nettype wire

// ----- src/atr_back.sv -----
// atr_back: range ring, running sum, fill count, divide and result register
// depends on atr_pkg, atr_ram and atr_div
`default_nettype none

module atr_back #(
   parameter int PRICE_BITS = 32,
   parameter int MAX_WINDOW = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         clear,
   input  wire logic [atr_pkg::CNT_W-1:0]    win,
   input  wire logic                         queue_empty,
   input  wire logic [PRICE_BITS-1:0]        queue_data,
   output logic                              queue_pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [PRICE_BITS-1:0]        rsp_true_range,
   output logic      [PRICE_BITS-1:0]        rsp_average_range,
   output logic      [atr_pkg::CNT_W-1:0]    rsp_ranges_averaged
);

   localparam int CNT_W  = atr_pkg::CNT_W;
   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int SUM_W  = PRICE_BITS + CNT_W;
   localparam int CMP_W  = (SLOT_W + 1 > CNT_W) ? SLOT_W + 1 : CNT_W;

   atr_pkg::back_state_type state_ff, state_in;

   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  evict_ff, evict_in;
   logic [PRICE_BITS-1:0] tr_ff, tr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PRICE_BITS-1:0] rsp_tr_ff, rsp_avg_ff;
   logic [CNT_W-1:0]      rsp_cnt_ff;

   logic                  ram_wr;
   logic [SLOT_W-1:0]     slot_use;
   logic [CMP_W-1:0]      slot_inc;
   logic [PRICE_BITS-1:0] ram_rd_data;
   logic                  div_start, div_done;
   logic [SUM_W-1:0]      div_quotient;
   logic                  rsp_load;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_true_range      = rsp_tr_ff;
   assign rsp_average_range   = rsp_avg_ff;
   assign rsp_ranges_averaged = rsp_cnt_ff;

   // slot is kept below the window, this only guards the wrap
   assign slot_use = (CMP_W'(slot_ff) >= CMP_W'(win)) ? '0 : slot_ff;
   assign slot_inc = CMP_W'(slot_ff) + CMP_W'(1);

   atr_ram #(
      .WIDTH (PRICE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (slot_ff),
      .wr_data (tr_ff),
      .rd_addr (slot_use),
      .rd_data (ram_rd_data)
   );

   atr_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .abort    (clear),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (fill_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         atr_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               state_in = atr_pkg::BK_UPDATE;
            end
         end
         atr_pkg::BK_UPDATE: begin
            state_in = atr_pkg::BK_DIVIDE;
         end
         atr_pkg::BK_DIVIDE: begin
            if (div_done) begin
               state_in = atr_pkg::BK_OUTPUT;
            end
         end
         atr_pkg::BK_OUTPUT: begin
            if (rsp_load) begin
               state_in = atr_pkg::BK_IDLE;
            end
         end
         default: state_in = atr_pkg::BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      queue_pop = 1'b0;
      ram_wr    = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         atr_pkg::BK_IDLE:   queue_pop = !queue_empty;
         atr_pkg::BK_UPDATE: begin
            ram_wr    = 1'b1;
            div_start = 1'b1;
         end
         atr_pkg::BK_DIVIDE: ;
         atr_pkg::BK_OUTPUT: rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // datapath: add the new range on pop, drop the oldest once the ring read is back
   always_comb begin
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      evict_in     = evict_ff;
      tr_in        = tr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (queue_pop) begin
         tr_in    = queue_data;
         slot_in  = slot_use;
         evict_in = (fill_ff >= win);
         sum_in   = sum_ff + SUM_W'(queue_data);
      end
      if (ram_wr) begin
         slot_in = (slot_inc >= CMP_W'(win)) ? '0 : slot_inc[SLOT_W-1:0];
         if (evict_ff) begin
            sum_in  = sum_ff - SUM_W'(ram_rd_data);
            fill_in = win;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         state_ff <= atr_pkg::BK_IDLE;
         slot_ff  <= '0;
         fill_ff  <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      evict_ff <= evict_in;
      tr_ff    <= tr_in;
      if (rsp_load) begin
         rsp_tr_ff  <= tr_ff;
         rsp_avg_ff <= div_quotient[PRICE_BITS-1:0];
         rsp_cnt_ff <= fill_ff;
      end
   end

   a_fill_in_window: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= win)
      else $error("fill count above window");

   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(slot_ff) < CMP_W'(win))
      else $error("ring slot outside window");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == atr_pkg::BK_DIVIDE)
      else $error("divider finished outside divide state");

   a_fill_moves_on_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == atr_pkg::BK_UPDATE && !clear) |=> fill_ff != '0)
      else $error("fill count zero after an update");

endmodule

`default_nettype wire

// ----- src/average_true_range_tracker_core.sv -----
// average_true_range_tracker_core: top level, config registers and the two halves
// depends on atr_pkg, atr_front, atr_fifo, atr_back (atr_ram, atr_div)
//
//   port group   dir   handshake           payload
//   req_*        in    req_valid/req_stall high, low, close prices
//   rsp_*        out   rsp_valid/rsp_stall true range, average range, count
//   csr_*        in    csr_we              csr_index, csr_wdata
//
// in the back end each word waits on the one-bit-per-cycle divide of the
// running sum by the fill count. the front end takes a word every cycle, unless
// a full queue holds its stage, into a two-word queue, so words can arrive while
// a result waits. reset is synchronous and clears all control state;
// ring contents need no clearing. any csr write restarts the history.
`default_nettype none

module average_true_range_tracker_core #(
   parameter int MAX_WINDOW = 256,
   parameter int PRICE_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [PRICE_BITS-1:0]             req_high_price,
   input  wire logic [PRICE_BITS-1:0]             req_low_price,
   input  wire logic [PRICE_BITS-1:0]             req_close_price,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [PRICE_BITS-1:0]             rsp_true_range,
   output logic      [PRICE_BITS-1:0]             rsp_average_range,
   output logic      [atr_pkg::CNT_W-1:0]         rsp_ranges_averaged,
   input  wire logic                              csr_we,
   input  wire logic [atr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [PRICE_BITS-1:0]             csr_wdata
);

   localparam int CNT_W = atr_pkg::CNT_W;

   logic [CNT_W-1:0]      window_ff, window_in;
   logic [PRICE_BITS-1:0] close_init_ff, close_init_in;
   logic [CNT_W-1:0]      win;
   logic                  q_push, q_pop, q_full, q_empty;
   logic [PRICE_BITS-1:0] q_push_data, q_pop_data;

   // register decode; every write restarts the history
   always_comb begin
      window_in     = window_ff;
      close_init_in = close_init_ff;
      if (csr_we) begin
         unique case (atr_pkg::csr_index_type'(csr_index))
            atr_pkg::CSR_WINDOW_LENGTH: window_in     = csr_wdata[CNT_W-1:0];
            atr_pkg::CSR_INITIAL_CLOSE: close_init_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= atr_pkg::WINDOW_RESET;
         close_init_ff <= PRICE_BITS'(atr_pkg::CLOSE_RESET);
      end else begin
         window_ff     <= window_in;
         close_init_ff <= close_init_in;
      end
   end

   // zero acts as one, above the ring depth saturates
   always_comb begin
      if (window_ff == '0) begin
         win = CNT_W'(1);
      end else if (32'(window_ff) > MAX_WINDOW) begin
         win = CNT_W'(MAX_WINDOW);
      end else begin
         win = window_ff;
      end
   end

   atr_front #(
      .PRICE_BITS (PRICE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .clear           (csr_we),
      .clear_close     (close_init_in),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_high_price  (req_high_price),
      .req_low_price   (req_low_price),
      .req_close_price (req_close_price),
      .queue_full      (q_full),
      .queue_push      (q_push),
      .queue_data      (q_push_data)
   );

   atr_fifo #(
      .WIDTH (PRICE_BITS),
      .DEPTH (atr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   atr_back #(
      .PRICE_BITS (PRICE_BITS),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .clear               (csr_we),
      .win                 (win),
      .queue_empty         (q_empty),
      .queue_data          (q_pop_data),
      .queue_pop           (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_true_range      (rsp_true_range),
      .rsp_average_range   (rsp_average_range),
      .rsp_ranges_averaged (rsp_ranges_averaged)
   );

endmodule

`default_nettype wire

// ----- sim/average_true_range_tracker_core_tb.sv -----
// average_true_range_tracker_core_tb: self-checking bench for the true range tracker core
// drives price bars and csr writes, predicts each result word in a small scoreboard class
// depends on atr_pkg and average_true_range_tracker_core under src
`timescale 1ns / 100ps

module average_true_range_tracker_core_tb;

   localparam int PRICE_W = 32;
   localparam int QUIET_LIMIT = 4000;

   typedef struct packed {
      logic [PRICE_W-1:0]        true_range;
      logic [PRICE_W-1:0]        average_range;
      logic [atr_pkg::CNT_W-1:0] ranges_averaged;
   } range_word_type;

   // predicts one result word per bar and checks the core's words in order
   class atr_scoreboard_type;
      logic [atr_pkg::CNT_W-1:0] window_reg;
      logic [PRICE_W-1:0]        close_reg;
      logic [PRICE_W-1:0]        range_hist [256];
      int unsigned               next_slot;
      int unsigned               ranges_held;
      logic [39:0]               range_total;
      logic [PRICE_W-1:0]        close_before;
      range_word_type            expected_ranges [$];
      int unsigned               mismatches;
      int unsigned               words_matched;

      function new();
         window_reg = atr_pkg::WINDOW_RESET;
         close_reg = atr_pkg::CLOSE_RESET[PRICE_W-1:0];
         mismatches = 0;
         words_matched = 0;
         restart();
      endfunction

      function void restart();
         next_slot = 0;
         ranges_held = 0;
         range_total = '0;
         close_before = close_reg;
      endfunction

      // any write restarts the history
      function void write_reg(atr_pkg::csr_index_type idx, logic [PRICE_W-1:0] value);
         case (idx)
            atr_pkg::CSR_WINDOW_LENGTH: window_reg = value[atr_pkg::CNT_W-1:0];
            atr_pkg::CSR_INITIAL_CLOSE: close_reg = value;
            default: ;
         endcase
         restart();
      endfunction

      function logic [PRICE_W-1:0] distance(logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
         return (a >= b) ? a - b : b - a;
      endfunction

      function void note_bar(logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
                             logic [PRICE_W-1:0] cl);
         int unsigned        span;
         logic [PRICE_W-1:0] tr;
         logic [39:0]        mean;
         range_word_type     w;
         span = (window_reg == 0) ? 1 : (window_reg > 256) ? 256 : window_reg;
         // low above high leaves only the distances from the previous close
         tr = (hi >= lo) ? hi - lo : '0;
         if (distance(hi, close_before) > tr) tr = distance(hi, close_before);
         if (distance(lo, close_before) > tr) tr = distance(lo, close_before);
         if (next_slot >= span) next_slot = 0;
         if (ranges_held >= span) begin
            range_total = range_total - range_hist[next_slot];
            ranges_held = span;
         end else begin
            ranges_held++;
         end
         range_hist[next_slot] = tr;
         range_total = range_total + tr;
         next_slot++;
         if (next_slot >= span) next_slot = 0;
         close_before = cl;
         mean = range_total / ranges_held;
         w.true_range = tr;
         w.average_range = mean[PRICE_W-1:0];
         w.ranges_averaged = ranges_held[atr_pkg::CNT_W-1:0];
         expected_ranges = {expected_ranges, w};
      endfunction

      function void check_range(range_word_type got);
         range_word_type want;
         if (expected_ranges.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: tr %h avg %h n %0d",
                        got.true_range, got.average_range, got.ranges_averaged);
            return;
         end
         want = expected_ranges.pop_front();
         words_matched++;
         if (got.true_range !== want.true_range || got.average_range !== want.average_range
             || got.ranges_averaged !== want.ranges_averaged) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected tr %h avg %h n %0d, got tr %h avg %h n %0d",
                        want.true_range, want.average_range, want.ranges_averaged,
                        got.true_range, got.average_range, got.ranges_averaged);
         end
      endfunction

      function int unsigned pending();
         return expected_ranges.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [PRICE_W-1:0]              req_high_price = '0;
   logic [PRICE_W-1:0]              req_low_price = '0;
   logic [PRICE_W-1:0]              req_close_price = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [PRICE_W-1:0]              rsp_true_range;
   logic [PRICE_W-1:0]              rsp_average_range;
   logic [atr_pkg::CNT_W-1:0]       rsp_ranges_averaged;
   logic                            csr_we = 1'b0;
   logic [atr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [PRICE_W-1:0]              csr_wdata = '0;

   atr_scoreboard_type scoreboard;
   int unsigned        bars_sent = 0;
   int unsigned        idle_pct = 0;
   int unsigned        stall_pct = 0;
   int unsigned        quiet_cycles = 0;

   average_true_range_tracker_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_high_price      (req_high_price),
      .req_low_price       (req_low_price),
      .req_close_price     (req_close_price),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_true_range      (rsp_true_range),
      .rsp_average_range   (rsp_average_range),
      .rsp_ranges_averaged (rsp_ranges_averaged),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watch both channels and the csr port at every edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            scoreboard.write_reg(atr_pkg::csr_index_type'(csr_index), csr_wdata);
         if (req_valid && !req_stall)
            scoreboard.note_bar(req_high_price, req_low_price, req_close_price);
         if (rsp_valid && !rsp_stall)
            scoreboard.check_range('{rsp_true_range, rsp_average_range, rsp_ranges_averaged});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("** average_true_range_tracker_core: FAILED **");
      $finish;
   end

   task automatic send_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
                           input logic [PRICE_W-1:0] cl);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_high_price <= hi;
      req_low_price <= lo;
      req_close_price <= cl;
      do @(posedge clock); while (req_stall);
      bars_sent++;
   endtask

   // hold the sender off until every word sent has come back
   task automatic drain_bars();
      req_valid <= 1'b0;
      while (scoreboard.words_matched != bars_sent) @(posedge clock);
   endtask

   task automatic apply_settings(input bit set_window, input logic [PRICE_W-1:0] window_word,
                                 input bit set_close, input logic [PRICE_W-1:0] close_word);
      drain_bars();
      if (set_window) begin
         csr_we <= 1'b1;
         csr_index <= atr_pkg::CSR_WINDOW_LENGTH;
         csr_wdata <= window_word;
         @(posedge clock);
      end
      if (set_close) begin
         csr_we <= 1'b1;
         csr_index <= atr_pkg::CSR_INITIAL_CLOSE;
         csr_wdata <= close_word;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic void random_bar(input bit wide, output logic [PRICE_W-1:0] hi,
                                      output logic [PRICE_W-1:0] lo,
                                      output logic [PRICE_W-1:0] cl);
      logic [PRICE_W-1:0] a;
      logic [PRICE_W-1:0] b;
      int unsigned        pick;
      pick = $urandom_range(99);
      a = $urandom;
      b = $urandom;
      if (wide) begin
         // near full-scale ranges push the running sum toward its top bits
         hi = ~(a >> 20);
         lo = b >> 20;
      end else if (pick < 45) begin
         lo = a >> 1;
         hi = lo + (b >> $urandom_range(31, 8));
      end else if (pick < 75) begin
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
      end else if (pick < 88) begin
         hi = (a < b) ? a : b;
         lo = (a < b) ? b : a;
      end else begin
         hi = ($urandom_range(2) == 0) ? '0 : ($urandom_range(1) == 0) ? '1 : a;
         lo = ($urandom_range(2) == 0) ? '0 : ($urandom_range(1) == 0) ? '1 : b;
      end
      cl = (hi >= lo) ? $urandom_range(hi, lo) : $urandom;
      if (pick >= 95) cl = ($urandom_range(1) == 0) ? '0 : '1;
   endfunction

   initial begin
      logic [PRICE_W-1:0] hi;
      logic [PRICE_W-1:0] lo;
      logic [PRICE_W-1:0] cl;
      logic [PRICE_W-1:0] win_value;
      logic [PRICE_W-1:0] cls_value;
      logic [PRICE_W-1:0] close_now;
      bit                 set_win;
      bit                 set_cls;
      bit                 wide;

      scoreboard = new();
      close_now = atr_pkg::CLOSE_RESET[PRICE_W-1:0];
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: window of 14, previous close of 100.0
      send_bar(32'h0065_0000, 32'h0063_0000, 32'h0064_8000);
      send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_bar(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_bar(32'h0000_0010, 32'h0000_0020, 32'h0000_0015);   // low above high
      send_bar(32'h0000_0015, 32'h0000_0015, 32'h0000_0015);   // flat bar at the close
      send_bar(32'h8000_0000, 32'h7FFF_0000, 32'h7FFF_8000);   // gap up
      send_bar(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);   // gap down
      send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // run past the window so the oldest range drops out
      repeat (10) begin
         random_bar(1'b0, hi, lo, cl);
         send_bar(hi, lo, cl);
      end

      for (int phase = 0; phase < 12; phase++) begin
         set_win = 1'b1;
         set_cls = 1'b1;
         wide = 1'b0;
         win_value = $urandom_range(40, 2);
         cls_value = $urandom;
         case (phase)
            0: begin
               win_value = 1;
               cls_value = '0;
            end
            1: begin
               win_value = 256;
               cls_value = '1;
               wide = 1'b1;
            end
            2: begin
               win_value = 0;                  // zero acts as a window of one
               set_cls = 1'b0;
            end
            3: begin
               win_value = 511;                // saturates to the largest window
               wide = 1'b1;
            end
            4: begin
               win_value = 257;
               set_cls = 1'b0;
            end
            6: begin
               set_win = 1'b0;                 // same close again still clears history
               cls_value = close_now;
            end
            7: win_value = 2;
            8: win_value = $urandom_range(511);
            9: begin
               win_value = 256;
               cls_value = 32'h8000_0000;
               wide = 1'b1;
            end
            10: win_value = $urandom_range(20, 1);
            11: begin
               win_value = atr_pkg::WINDOW_RESET;
               cls_value = atr_pkg::CLOSE_RESET[PRICE_W-1:0];
            end
            default: ;
         endcase
         if (set_cls) close_now = cls_value;
         apply_settings(set_win, ($urandom & 32'hFFFF_FE00) | win_value, set_cls, cls_value);
         case (phase % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 57;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 57;
            end
            default: begin
               idle_pct = 18;
               stall_pct = 18;
            end
         endcase
         for (int n = 0; n < 136; n++) begin
            if (phase == 5 && n == 68) drain_bars();
            random_bar(wide, hi, lo, cl);
            send_bar(hi, lo, cl);
         end
      end

      drain_bars();
      repeat (60) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
         $display("** average_true_range_tracker_core: PASSED **");
      end else begin
         $display("** average_true_range_tracker_core: FAILED **");
      end
      $finish;
   end

endmodule
